FILE: rtl/core/tsqm_pkg.sv
// shared types, constants and helper functions of the touch sample qualify and map block
package tsqm_pkg;

  // adc code and screen geometry
  localparam int unsigned CODE_W        = 12;
  localparam logic [CODE_W-1:0] CODE_FULL = 12'hFFF;
  localparam int unsigned SCREEN_WIDTH  = 240;
  localparam int unsigned SCREEN_HEIGHT = 320;
  localparam int unsigned SIZE_MAX      = (SCREEN_WIDTH > SCREEN_HEIGHT) ?
                                          SCREEN_WIDTH : SCREEN_HEIGHT;

  // quotient and numerator widths of the axis divider
  localparam int unsigned Q_W        = $clog2(SIZE_MAX);
  localparam int unsigned NUM_W      = CODE_W + Q_W;
  localparam int unsigned DIV_BITS   = 3;
  localparam int unsigned DIV_STAGES = (Q_W + DIV_BITS - 1) / DIV_BITS;

  localparam logic [Q_W-1:0] LAST_X = Q_W'(SCREEN_WIDTH - 1);
  localparam logic [Q_W-1:0] LAST_Y = Q_W'(SCREEN_HEIGHT - 1);

  // output field widths
  localparam int unsigned SX_W = 8;
  localparam int unsigned SY_W = 9;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_X_MIN     = 3'd0,
    REG_X_MAX     = 3'd1,
    REG_Y_MIN     = 3'd2,
    REG_Y_MAX     = 3'd3,
    REG_SWAP_AXES = 3'd4,
    REG_MIRROR_X  = 3'd5,
    REG_MIRROR_Y  = 3'd6,
    REG_PRESS_THR = 3'd7
  } cfg_reg_e;

  // one axis after range decode
  typedef struct packed {
    logic [CODE_W-1:0] diff;
    logic [CODE_W-1:0] den;
    logic              neg;
    logic              sat;
    logic              degen;
  } axis_pre_t;

  // one axis inside the divider
  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [Q_W-1:0]    quo;
    logic [CODE_W-1:0] den;
    logic              neg;
    logic              sat;
    logic              degen;
  } axis_div_t;

  // range decode of one axis
  function automatic axis_pre_t axis_decode(logic [CODE_W-1:0] code,
                                            logic [CODE_W-1:0] lo,
                                            logic [CODE_W-1:0] hi);
    axis_pre_t r;
    r.degen = (hi <= lo);
    r.neg   = (code < lo);
    r.sat   = (code >= hi);
    r.diff  = code - lo;
    r.den   = hi - lo;
    return r;
  endfunction

  // one restoring division step producing quotient bit bit_idx
  function automatic axis_div_t div_step(axis_div_t a, int unsigned bit_idx);
    logic [NUM_W:0] trial;
    axis_div_t      r;
    r     = a;
    trial = {1'b0, NUM_W'(a.den)} << bit_idx;
    if ({1'b0, a.rem} >= trial) begin
      r.rem = a.rem - trial[NUM_W-1:0];
      r.quo = a.quo | (Q_W'(1) << bit_idx);
    end
    return r;
  endfunction

  // mirror and clamp of one mapped axis
  function automatic logic [Q_W-1:0] axis_finish(axis_div_t a, logic mirror,
                                                 logic [Q_W-1:0] last);
    logic [Q_W-1:0] v;
    if (a.degen || a.neg) begin
      v = mirror ? last : '0;
    end else if (a.sat) begin
      v = mirror ? '0 : last;
    end else begin
      v = mirror ? (last - a.quo) : a.quo;
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/touch_sample_qualify_and_map_top.sv
// touch sample qualification and min/max linear mapping to screen coordinates
//
//  channel  | direction | transfer                  | payload
//  ---------+-----------+---------------------------+---------------------------------------
//  s_axis   | in        | tvalid & tready           | tuser: pen_down; tdata: x, y, z1, z2
//  m_axis   | out       | tvalid & tready           | tuser: touched; tdata: screen_x, y
//  cfg      | in        | cfg_valid_i & cfg_ready_o | cfg_addr_i register, cfg_data_i value
//
//  one sample per cycle sustained while m_axis accepts; the pipeline is stage 1, stage 2,
//  DIV_STAGES restoring divider stages and the output stage, three quotient bits per stage.
//  reset clears all valid bits and loads the register defaults; configuration always ready.
//  a stall on m_axis holds every stage that cannot move, bubbles are squeezed out.
module touch_sample_qualify_and_map_top
  import tsqm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // raw_x, raw_y, pressure_z1, pressure_z2
  input  logic [0:0]          s_axis_tuser,  // pen_down

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // screen_x, screen_y, zero fill
  output logic [0:0]          m_axis_tuser,  // touched

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_addr_i,
  input  logic [CODE_W-1:0]   cfg_data_i
);

  // configuration registers
  logic [CODE_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q, thr_q;
  logic              swap_q, mirror_x_q, mirror_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q    <= '0;
      x_max_q    <= CODE_FULL;
      y_min_q    <= '0;
      y_max_q    <= CODE_FULL;
      swap_q     <= 1'b0;
      mirror_x_q <= 1'b0;
      mirror_y_q <= 1'b0;
      thr_q      <= CODE_W'(60);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_X_MIN:     x_min_q    <= cfg_data_i;
        REG_X_MAX:     x_max_q    <= cfg_data_i;
        REG_Y_MIN:     y_min_q    <= cfg_data_i;
        REG_Y_MAX:     y_max_q    <= cfg_data_i;
        REG_SWAP_AXES: swap_q     <= cfg_data_i[0];
        REG_MIRROR_X:  mirror_x_q <= cfg_data_i[0];
        REG_MIRROR_Y:  mirror_y_q <= cfg_data_i[0];
        REG_PRESS_THR: thr_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline valid bits and ready chain
  logic                  v1_q, v2_q, vo_q;
  logic [DIV_STAGES-1:0] dv_q;
  logic                  rdy1, rdy2, rdy_o;
  logic [DIV_STAGES-1:0] drdy;

  assign rdy_o = !vo_q || m_axis_tready;
  always_comb begin
    drdy[DIV_STAGES-1] = !dv_q[DIV_STAGES-1] || rdy_o;
    for (int s = DIV_STAGES - 2; s >= 0; s--) begin
      drdy[s] = !dv_q[s] || drdy[s+1];
    end
  end
  assign rdy2          = !v2_q || drdy[0];
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      dv_q <= '0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (drdy[0]) dv_q[0] <= v2_q;
      for (int s = 1; s < DIV_STAGES; s++) begin
        if (drdy[s]) dv_q[s] <= dv_q[s-1];
      end
      if (rdy_o) vo_q <= dv_q[DIV_STAGES-1];
    end
  end

  // stage 1: qualification, axis swap and range decode
  logic [CODE_W-1:0] raw_x, raw_y, z1, z2, press, ax, ay;
  logic              qual_d, qual1_q;
  axis_pre_t         px_d, py_d, px_q, py_q;

  assign raw_x = s_axis_tdata[11:0];
  assign raw_y = s_axis_tdata[23:12];
  assign z1    = s_axis_tdata[35:24];
  assign z2    = s_axis_tdata[47:36];

  always_comb begin
    press  = (z2 >= z1) ? (z2 - z1) : (z1 - z2);
    qual_d = s_axis_tuser[0] && (press >= thr_q) &&
             (raw_x != '0) && (raw_x != CODE_FULL) &&
             (raw_y != '0) && (raw_y != CODE_FULL);
    ax     = swap_q ? raw_y : raw_x;
    ay     = swap_q ? raw_x : raw_y;
    px_d   = axis_decode(ax, x_min_q, x_max_q);
    py_d   = axis_decode(ay, y_min_q, y_max_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      qual1_q <= qual_d;
      px_q    <= px_d;
      py_q    <= py_d;
    end
  end

  // stage 2: numerator product
  logic      qual2_q;
  axis_div_t dx2_d, dy2_d, dx2_q, dy2_q;

  always_comb begin
    dx2_d.rem   = NUM_W'(px_q.diff) * NUM_W'(LAST_X);
    dx2_d.quo   = '0;
    dx2_d.den   = px_q.den;
    dx2_d.neg   = px_q.neg;
    dx2_d.sat   = px_q.sat;
    dx2_d.degen = px_q.degen;
    dy2_d.rem   = NUM_W'(py_q.diff) * NUM_W'(LAST_Y);
    dy2_d.quo   = '0;
    dy2_d.den   = py_q.den;
    dy2_d.neg   = py_q.neg;
    dy2_d.sat   = py_q.sat;
    dy2_d.degen = py_q.degen;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      qual2_q <= qual1_q;
      dx2_q   <= dx2_d;
      dy2_q   <= dy2_d;
    end
  end

  // divider stages, quotient bits from the top down
  axis_div_t [DIV_STAGES-1:0] dx_q, dy_q;
  logic      [DIV_STAGES-1:0] dqual_q;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    axis_div_t sx_in, sy_in, sx_d, sy_d;
    logic      sq_in;

    if (s == 0) begin : g_head
      assign sx_in = dx2_q;
      assign sy_in = dy2_q;
      assign sq_in = qual2_q;
    end else begin : g_body
      assign sx_in = dx_q[s-1];
      assign sy_in = dy_q[s-1];
      assign sq_in = dqual_q[s-1];
    end

    always_comb begin
      int idx;
      sx_d = sx_in;
      sy_d = sy_in;
      for (int k = 0; k < DIV_BITS; k++) begin
        idx = int'(Q_W) - 1 - (s * int'(DIV_BITS) + k);
        if (idx >= 0) begin
          sx_d = div_step(sx_d, unsigned'(idx));
          sy_d = div_step(sy_d, unsigned'(idx));
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (drdy[s]) begin
        dqual_q[s] <= sq_in;
        dx_q[s]    <= sx_d;
        dy_q[s]    <= sy_d;
      end
    end
  end

  // output stage: mirror, clamp and zero for rejected samples
  logic [Q_W-1:0]  fx, fy;
  logic [SX_W-1:0] sx_d, sx_q;
  logic [SY_W-1:0] sy_d, sy_q;
  logic            touched_q;

  always_comb begin
    fx   = axis_finish(dx_q[DIV_STAGES-1], mirror_x_q, LAST_X);
    fy   = axis_finish(dy_q[DIV_STAGES-1], mirror_y_q, LAST_Y);
    sx_d = dqual_q[DIV_STAGES-1] ? SX_W'(fx) : '0;
    sy_d = dqual_q[DIV_STAGES-1] ? SY_W'(fy) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      touched_q <= dqual_q[DIV_STAGES-1];
      sx_q      <= sx_d;
      sy_q      <= sy_d;
    end
  end

  assign m_axis_tvalid   = vo_q;
  assign m_axis_tuser[0] = touched_q;
  assign m_axis_tdata    = {7'd0, sy_q, sx_q};

endmodule
